### src/rmw_pkg.sv
`timescale 1ns / 1ps
package rmw_pkg;

	localparam int DEPTH = 64;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	typedef logic signed [31:0] sample_t;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_CLEAR  = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_ABSENT = 2'd2
	} status_t;

	typedef struct packed {
		logic ins;
		logic rem;
	} cell_op_t;

endpackage

### src/rmw_cell.sv
`timescale 1ns / 1ps
module rmw_cell
	import rmw_pkg::*;
(
	input  logic     clk,
	input  cell_op_t op,
	input  sample_t  v,
	input  logic     in_range,
	input  logic     left_gt,
	input  sample_t  left_val,
	input  sample_t  right_val,
	output logic     gt,
	output logic     eq,
	output sample_t  val
);

	sample_t val_q;

	// empty slots act as plus infinity
	assign gt  = !in_range || (val_q > v);
	assign eq  = in_range && (val_q == v);
	assign val = val_q;

	always_ff @(posedge clk) begin
		if (op.ins && gt) begin
			val_q <= left_gt ? left_val : v;
		end else if (op.rem && in_range && (val_q >= v)) begin
			val_q <= right_val;
		end
	end

endmodule

### src/rmw_median.sv
`timescale 1ns / 1ps
module rmw_median
	import rmw_pkg::*;
(
	input  logic             clk,
	input  logic             load,
	input  logic [CNT_W-1:0] count,
	input  sample_t          cells [DEPTH],
	output sample_t          median
);

	logic [IDX_W-1:0] hi_idx;
	logic [IDX_W-1:0] lo_idx;
	sample_t          hi_sel;
	sample_t          lo_sel;
	sample_t          hi_s1;
	sample_t          lo_s1;
	logic             odd_s1;
	logic             empty_s1;
	logic [32:0]      sum;

	assign hi_idx = IDX_W'(count >> 1);
	assign lo_idx = hi_idx - IDX_W'(1);

	always_comb begin
		hi_sel = '0;
		lo_sel = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (hi_idx == IDX_W'(i)) hi_sel = hi_sel | cells[i];
			if (lo_idx == IDX_W'(i)) lo_sel = lo_sel | cells[i];
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			hi_s1    <= hi_sel;
			lo_s1    <= lo_sel;
			odd_s1   <= count[0];
			empty_s1 <= (count == '0);
		end
	end

	// 33-bit sum, arithmetic shift right by one
	assign sum = {lo_s1[31], lo_s1} + {hi_s1[31], hi_s1};

	always_comb begin
		if (empty_s1) begin
			median = '0;
		end else if (odd_s1) begin
			median = hi_s1;
		end else begin
			median = sample_t'(sum[32:1]);
		end
	end

endmodule

### src/running_median_window.sv
`timescale 1ns / 1ps
// Running median over a sorted window of up to 64 signed Q16.16 samples, held in a row of
// compare-and-shift cells. An insert shifts every cell above the new value one place up, a
// remove shifts the cells from the first matching copy one place down, and a clear empties the
// window; all cells move in the same cycle as the request is taken. Each request yields one
// response with the median (mean of the two middle samples, rounded toward minus infinity, for
// an even count; 0 when empty), the count and a status. A request goes through the cell
// update, the registered pick of the middle entries, and the averaging into the output
// register, after which the response is valid. req_stall stays high until that response
// has been loaded into the output register, so no new request is taken before then; the
// next request is taken even while the previous response still waits on rsp_stall, and it
// then holds in the averaging step until the output register drains.
module running_median_window
	import rmw_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic [1:0]         command,
	input  logic signed [31:0] value,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic signed [31:0] median,
	output logic [6:0]         count,
	output logic [1:0]         status
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SEL  = 3'b010,
		S_SUM  = 3'b100
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] count_q;
	status_t          status_q;
	logic             rsp_valid_q;
	sample_t          median_q;
	logic [6:0]       count_out_q;
	logic [1:0]       status_out_q;

	logic             req_take;
	logic             rsp_load;
	logic             full;
	logic             found;
	cell_op_t         op;
	sample_t          cell_val [DEPTH];
	logic [DEPTH-1:0] cell_gt;
	logic [DEPTH-1:0] cell_eq;
	logic [DEPTH-1:0] in_range;
	sample_t          med_calc;

	assign req_stall = (state_q != S_IDLE);
	assign req_take  = req_valid && !req_stall;
	assign full      = (count_q == CNT_W'(DEPTH));
	assign found     = |cell_eq;
	assign rsp_load  = (state_q == S_SUM) && !(rsp_valid_q && rsp_stall);

	assign op.ins = req_take && (command == CMD_INSERT) && !full;
	assign op.rem = req_take && (command == CMD_REMOVE) && found;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		assign in_range[i] = (CNT_W'(i) < count_q);
		rmw_cell u_cell (
			.clk       (clk),
			.op        (op),
			.v         (value),
			.in_range  (in_range[i]),
			.left_gt   ((i == 0) ? 1'b0 : cell_gt[(i == 0) ? 0 : i - 1]),
			.left_val  (cell_val[(i == 0) ? 0 : i - 1]),
			.right_val (cell_val[(i == DEPTH - 1) ? i : i + 1]),
			.gt        (cell_gt[i]),
			.eq        (cell_eq[i]),
			.val       (cell_val[i])
		);
	end

	rmw_median u_median (
		.clk    (clk),
		.load   (state_q == S_SEL),
		.count  (count_q),
		.cells  (cell_val),
		.median (med_calc)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			status_q <= ST_OK;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_take) begin
						state_q  <= S_SEL;
						status_q <= ST_OK;
						case (command)
							CMD_INSERT: begin
								if (full) status_q <= ST_FULL;
								else count_q <= count_q + CNT_W'(1);
							end
							CMD_REMOVE: begin
								if (found) count_q <= count_q - CNT_W'(1);
								else status_q <= ST_ABSENT;
							end
							CMD_CLEAR: count_q <= '0;
							default: ;
						endcase
					end
				end
				S_SEL: state_q <= S_SUM;
				S_SUM: begin
					if (rsp_load) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			median_q     <= med_calc;
			count_out_q  <= 7'(count_q);
			status_out_q <= status_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign median    = median_q;
	assign count     = count_out_q;
	assign status    = status_out_q;

	a_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("state register not one-hot");

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("count above depth");

	a_take_sel: assert property (@(posedge clk) disable iff (!arst_n)
		req_take |=> (state_q == S_SEL))
		else $error("request taken without update step");

	a_full_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SEL && status_q == ST_FULL) |-> full)
		else $error("full status with room left");

	a_rsp_out: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_load |=> (rsp_valid_q && state_q == S_IDLE))
		else $error("response not presented after sum step");

endmodule
